@@ design/audio_frame_mixer_with_level_assert.svh @@
// Assertion helpers used by the mixer controller.
`ifndef AUDIO_FRAME_MIXER_WITH_LEVEL_ASSERT_SVH
`define AUDIO_FRAME_MIXER_WITH_LEVEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define AFML_ASSERT_NOW(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define AFML_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/afml_pkg.sv @@
package afml_pkg;

    // Default frame length; must be a power of two.
    localparam int FRAME_SAMPLES_DEF = 256;

    // Configuration register indexes.
    localparam logic REG_MASTER_GAIN  = 1'b0;
    localparam logic REG_LEVEL_ENABLE = 1'b1;

    // Item modes.
    localparam logic [1:0] MODE_MIX   = 2'd0;
    localparam logic [1:0] MODE_LEVEL = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    // Level meter constants.
    localparam logic [16:0] DB_PER_OCTAVE_Q16 = 17'd98642;
    localparam logic [24:0] FULL_SCALE_DB_Q16 = 25'd2959237;
    localparam logic signed [24:0] LEVEL_FLOOR = -25'sd10240;
    localparam logic signed [24:0] LEVEL_CEIL  = 25'sd400;
    localparam logic [30:0] MEAN_SMALL = 31'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic cnt_clr;
        logic cnt_inc;
        logic clr_wr;
        logic mx_rd;
        logic mx_mul;
        logic mx_wr;
        logic dr_rd;
        logic dr_wr;
        logic lv_rd;
        logic acc_clr;
        logic lv_mean;
        logic norm_shift;
        logic seed;
        logic iter;
        logic db;
        logic fin;
        logic hold_zero;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;
        logic iter_last;
        logic pipe_busy;
        logic x_msb;
        logic small_mean;
    } dp_status_t;

endpackage

@@ design/audio_frame_mixer_with_level.sv @@
// Channel   | Signals                                       | Direction
// --------- | --------------------------------------------- | ---------
// command   | start, busy, mode, position, sample_in,       | in/out
//           | source_gain                                   |
// result    | result_valid, dac_byte, level_estimate,       | out
//           | clip_flag                                     |
// config    | psel, penable, pwrite, paddr, pwdata, prdata, | in/out
//           | pready                                        |
//
// A mix item reads the stored entry, scales the sample and writes the sum back; a drain
// item reads the entry, then outputs and clears it; idle-mode and metering-off items skip the memory.
// A level item does one memory read per sample, a bit-serial normalising shift and
// sixteen squaring steps for the log; a near-silent frame skips the log.
// After reset a clearing pass writes zero to every entry, with busy high.
// Results are shown for one cycle; the receiver cannot stall.
module audio_frame_mixer_with_level
    import afml_pkg::*;
#(
    parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [7:0]         position,
    input  logic signed [15:0] sample_in,
    input  logic [7:0]         source_gain,
    output logic               result_valid,
    output logic [7:0]         dac_byte,
    output logic signed [14:0] level_estimate,
    output logic               clip_flag
);

    logic [7:0] master_gain_reg;
    logic       level_enable_reg;
    logic       cfg_wr;
    ctrl_cmd_t  cmd;
    dp_status_t st;

    // Configuration registers.
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_gain_reg  <= 8'd255;
            level_enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MASTER_GAIN:  master_gain_reg  <= pwdata[7:0];
                REG_LEVEL_ENABLE: level_enable_reg <= pwdata[0];
                default:          master_gain_reg  <= master_gain_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LEVEL_ENABLE) ? {31'd0, level_enable_reg}
                                                   : {24'd0, master_gain_reg};

    afml_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (mode),
        .level_enable (level_enable_reg),
        .st           (st),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    afml_dp #(
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .master_gain    (master_gain_reg),
        .position       (position),
        .sample_in      (sample_in),
        .source_gain    (source_gain),
        .dac_byte       (dac_byte),
        .level_estimate (level_estimate),
        .clip_flag      (clip_flag)
    );

endmodule

@@ design/afml_dp.sv @@
module afml_dp
    import afml_pkg::*;
#(
    parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         st,
    input  logic [7:0]         master_gain,
    input  logic [7:0]         position,
    input  logic signed [15:0] sample_in,
    input  logic [7:0]         source_gain,
    output logic [7:0]         dac_byte,
    output logic signed [14:0] level_estimate,
    output logic               clip_flag
);

    localparam int AW    = $clog2(FRAME_SAMPLES);
    localparam int ACC_W = 31 + AW;

    logic [15:0] mem [FRAME_SAMPLES];

    logic [AW-1:0]        idx_reg;
    logic signed [15:0]   sample_reg;
    logic [7:0]           sgain_reg;
    logic [AW-1:0]        cnt_reg;
    logic signed [15:0]   rd_data_reg;
    logic                 rdv_reg;
    logic                 sqv_reg;
    logic [31:0]          sq_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [15:0]          gprod_reg;
    logic signed [32:0]   prod_reg;
    logic [31:0]          x_reg;
    logic                 small_reg;
    logic [4:0]           nshift_reg;
    logic [30:0]          y_reg;
    logic [15:0]          frac_reg;
    logic [21:0]          db_reg;
    logic signed [14:0]   level_hold_reg;
    logic signed [14:0]   level_hold_next;
    logic                 clip_reg;
    logic [7:0]           dac_reg;

    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_wa;
    logic [AW-1:0]        mem_ra;
    logic [15:0]          mem_wd;
    logic signed [17:0]   mix_sum;
    logic [15:0]          mix_sat;
    logic                 mix_clip;
    logic [ACC_W-1:0]     mean_full;
    logic [61:0]          y_sq;
    logic [31:0]          y_new;
    logic [20:0]          log_q16;
    logic [37:0]          db_prod;
    logic [22:0]          t_val;
    logic signed [24:0]   diff;
    logic signed [24:0]   lv_raw;

    // Frame memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign mem_we = cmd.clr_wr | cmd.mx_wr | cmd.dr_wr;
    assign mem_re = cmd.mx_rd | cmd.dr_rd | cmd.lv_rd;
    assign mem_wa = cmd.clr_wr ? cnt_reg : idx_reg;
    assign mem_ra = cmd.lv_rd ? cnt_reg : idx_reg;
    assign mem_wd = cmd.mx_wr ? mix_sat : 16'd0;

    // Saturating add of the scaled sample to the stored entry.
    always_comb
    begin
        mix_sum  = 18'(rd_data_reg) + 18'($signed(prod_reg[32:16]));
        mix_clip = 1'b0;
        mix_sat  = mix_sum[15:0];
        if (mix_sum > 18'sd32767)
        begin
            mix_sat  = 16'h7FFF;
            mix_clip = 1'b1;
        end
        else if (mix_sum < -18'sd32768)
        begin
            mix_sat  = 16'h8000;
            mix_clip = 1'b1;
        end
    end

    // One squaring step of the log2 fraction.
    assign y_sq  = 62'(y_reg) * 62'(y_reg);
    assign y_new = y_sq[61:30];

    // Octaves to decibels, rounding and clamping.
    assign mean_full = acc_reg >> AW;
    assign log_q16   = {5'd31 - nshift_reg, frac_reg};
    assign db_prod   = 38'(log_q16) * 38'(DB_PER_OCTAVE_Q16);
    assign t_val     = 23'(db_reg) + 23'd128;
    assign diff      = $signed({2'b00, t_val}) - $signed(FULL_SCALE_DB_Q16);
    assign lv_raw    = diff >>> 8;

    always_comb
    begin
        level_hold_next = level_hold_reg;
        if (cmd.hold_zero)
        begin
            level_hold_next = '0;
        end
        else if (cmd.fin)
        begin
            if (small_reg || lv_raw < LEVEL_FLOOR)
            begin
                level_hold_next = 15'(LEVEL_FLOOR);
            end
            else if (lv_raw > LEVEL_CEIL)
            begin
                level_hold_next = 15'(LEVEL_CEIL);
            end
            else
            begin
                level_hold_next = lv_raw[14:0];
            end
        end
    end

    // Control registers: counter, pipeline valids, held level and clip flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            rdv_reg        <= 1'b0;
            sqv_reg        <= 1'b0;
            level_hold_reg <= '0;
            clip_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr || cmd.seed)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc || cmd.iter)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rdv_reg        <= cmd.lv_rd;
            sqv_reg        <= rdv_reg;
            level_hold_reg <= level_hold_next;
            if (cmd.mx_wr && mix_clip)
            begin
                clip_reg <= 1'b1;
            end
        end
    end

    // Payload registers of the arithmetic.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            idx_reg    <= AW'(position);
            sample_reg <= sample_in;
            sgain_reg  <= source_gain;
        end
        if (cmd.mx_rd)
        begin
            gprod_reg <= 16'(master_gain) * 16'(sgain_reg);
        end
        if (cmd.mx_mul)
        begin
            prod_reg <= $signed({1'b0, gprod_reg}) * sample_reg;
        end
        sq_reg <= 32'(rd_data_reg * rd_data_reg);
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (sqv_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(sq_reg);
        end
        if (cmd.lv_mean)
        begin
            x_reg      <= {mean_full[30:0], 1'b0};
            small_reg  <= (mean_full <= ACC_W'(MEAN_SMALL));
            nshift_reg <= '0;
        end
        else if (cmd.norm_shift)
        begin
            x_reg      <= {x_reg[30:0], 1'b0};
            nshift_reg <= nshift_reg + 5'd1;
        end
        if (cmd.seed)
        begin
            y_reg    <= x_reg[31:1];
            frac_reg <= '0;
        end
        else if (cmd.iter)
        begin
            y_reg    <= y_new[31] ? y_new[31:1] : y_new[30:0];
            frac_reg <= {frac_reg[14:0], y_new[31]};
        end
        if (cmd.db)
        begin
            db_reg <= db_prod[37:16];
        end
        if (cmd.dr_wr)
        begin
            dac_reg <= rd_data_reg[15:8] ^ 8'h80;
        end
        else if (cmd.finish)
        begin
            dac_reg <= 8'd0;
        end
    end

    assign st.cnt_last   = (cnt_reg == AW'(FRAME_SAMPLES - 1));
    assign st.iter_last  = (cnt_reg[3:0] == 4'd15);
    assign st.pipe_busy  = rdv_reg | sqv_reg;
    assign st.x_msb      = x_reg[31];
    assign st.small_mean = small_reg;

    assign dac_byte       = dac_reg;
    assign level_estimate = level_hold_reg;
    assign clip_flag      = clip_reg;

endmodule

@@ design/afml_ctrl.sv @@
`include "audio_frame_mixer_with_level_assert.svh"

module afml_ctrl
    import afml_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] mode,
    input  logic       level_enable,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       result_valid
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MX_RD    = 4'd2;
    localparam logic [3:0] S_MX_MUL   = 4'd3;
    localparam logic [3:0] S_MX_WR    = 4'd4;
    localparam logic [3:0] S_DR_RD    = 4'd5;
    localparam logic [3:0] S_DR_WR    = 4'd6;
    localparam logic [3:0] S_LV_WALK  = 4'd7;
    localparam logic [3:0] S_LV_FLUSH = 4'd8;
    localparam logic [3:0] S_LV_MEAN  = 4'd9;
    localparam logic [3:0] S_LV_NORM  = 4'd10;
    localparam logic [3:0] S_LV_ITER  = 4'd11;
    localparam logic [3:0] S_LV_DB    = 4'd12;
    localparam logic [3:0] S_LV_FIN   = 4'd13;
    localparam logic [3:0] S_LV_OFF   = 4'd14;
    localparam logic [3:0] S_NOP      = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       done_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (st.cnt_last)
                begin
                    cmd.cnt_inc = 1'b0;
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    unique case (mode)
                        MODE_MIX:   state_next = S_MX_RD;
                        MODE_DRAIN: state_next = S_DR_RD;
                        MODE_LEVEL:
                        begin
                            cmd.cnt_clr = 1'b1;
                            cmd.acc_clr = 1'b1;
                            state_next  = level_enable ? S_LV_WALK : S_LV_OFF;
                        end
                        default:    state_next = S_NOP;
                    endcase
                end
            end
            S_MX_RD:
            begin
                cmd.mx_rd  = 1'b1;
                state_next = S_MX_MUL;
            end
            S_MX_MUL:
            begin
                cmd.mx_mul = 1'b1;
                state_next = S_MX_WR;
            end
            S_MX_WR:
            begin
                cmd.mx_wr  = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_DR_RD:
            begin
                cmd.dr_rd  = 1'b1;
                state_next = S_DR_WR;
            end
            S_DR_WR:
            begin
                cmd.dr_wr  = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_LV_WALK:
            begin
                cmd.lv_rd   = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (st.cnt_last)
                begin
                    state_next = S_LV_FLUSH;
                end
            end
            S_LV_FLUSH:
            begin
                if (!st.pipe_busy)
                begin
                    state_next = S_LV_MEAN;
                end
            end
            S_LV_MEAN:
            begin
                cmd.lv_mean = 1'b1;
                state_next  = S_LV_NORM;
            end
            S_LV_NORM:
            begin
                priority if (st.small_mean)
                begin
                    state_next = S_LV_FIN;
                end
                else if (st.x_msb)
                begin
                    cmd.seed   = 1'b1;
                    state_next = S_LV_ITER;
                end
                else
                begin
                    cmd.norm_shift = 1'b1;
                end
            end
            S_LV_ITER:
            begin
                cmd.iter = 1'b1;
                if (st.iter_last)
                begin
                    state_next = S_LV_DB;
                end
            end
            S_LV_DB:
            begin
                cmd.db     = 1'b1;
                state_next = S_LV_FIN;
            end
            S_LV_FIN:
            begin
                cmd.fin    = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_LV_OFF:
            begin
                cmd.hold_zero = 1'b1;
                cmd.finish    = 1'b1;
                state_next    = S_IDLE;
            end
            S_NOP:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = done_reg;

    // Every finished item gives one result in the next cycle.
    `AFML_ASSERT_NEXT(a_finish_gives_result, clk, rst_n, cmd.finish, done_reg, "finish without result")
    // A result is shown only once the controller is back in idle.
    `AFML_ASSERT_NOW(a_result_in_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "result outside idle")
    // The clearing pass runs to its last entry.
    `AFML_ASSERT_NEXT(a_clear_runs, clk, rst_n, state_reg == S_CLEAR && !st.cnt_last, state_reg == S_CLEAR, "clear cut short")
    // The log stage starts only with the frame sum complete.
    `AFML_ASSERT_NOW(a_mean_after_flush, clk, rst_n, cmd.lv_mean, !st.pipe_busy, "mean taken early")

endmodule
